>>> src/rpct_pkg.sv
// shared constants, types and command codes for the range paint count tree
package rpct_pkg;

  localparam int unsigned LEAF_W = 10;
  localparam int unsigned LEAVES = 1 << LEAF_W;
  localparam int unsigned ADDR_W = LEAF_W + 1;
  localparam int unsigned NODES  = 1 << ADDR_W;
  localparam int unsigned CNT_W  = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEAF_W-1:0] cell_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_VISIT,
    OP_PUSHL,
    OP_PUSHR,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_RDL,
    OP_RDR,
    OP_SUM,
    OP_RDROOT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_PUSHR,
    S_DESC,
    S_UP,
    S_AFTER,
    S_RDR,
    S_SUM,
    S_OUTR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic clr_done;
    logic range_ok;
    logic covered;
    logic uniform;
    logic is_root;
    logic was_left;
    logic lo_le_mid;
    logic hi_gt_mid;
  } dp_status_t;

endpackage

>>> src/rpct_ram.sv
// generic single write, single registered read ram
module rpct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/rpct_dp.sv
// datapath: node pointer, node span, node count memory and sum
module rpct_dp import rpct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_op_e     op_i,
  input  cell_t      start_req_i,
  input  cell_t      end_req_i,
  input  logic       func_i,
  output dp_status_t status_o,
  output cnt_t       white_count_o
);

  addr_t w_q, w_d;
  cell_t l_q, l_d;
  cnt_t  size_q, size_d;
  cell_t lo_q, hi_q;
  logic  white_q;
  logic  was_left_q, was_left_d;
  cnt_t  left_q;
  addr_t clr_q, clr_d;

  logic  we, re;
  addr_t waddr, raddr;
  cnt_t  wdata, rdata;
  cnt_t  half, mid, p, push_val;

  assign half = size_q >> 1;
  assign mid  = cnt_t'(l_q) + half - cnt_t'(1);
  assign p    = cnt_t'(l_q) + size_q - cnt_t'(1);
  assign push_val = (rdata == size_q) ? half : '0;

  always_comb begin
    w_d        = w_q;
    l_d        = l_q;
    size_d     = size_q;
    was_left_d = was_left_q;
    clr_d      = clr_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = w_q;
    raddr      = w_q;
    wdata      = '0;
    unique case (op_i)
      OP_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + addr_t'(1);
      end
      OP_LOAD: begin
        w_d    = addr_t'(1);
        l_d    = '0;
        size_d = cnt_t'(LEAVES);
      end
      OP_VISIT: begin
        re = 1'b1;
        if (status_o.covered) begin
          we    = 1'b1;
          wdata = white_q ? size_q : '0;
        end
      end
      OP_PUSHL: begin
        we    = 1'b1;
        waddr = {w_q[ADDR_W-2:0], 1'b0};
        wdata = push_val;
      end
      OP_PUSHR: begin
        we    = 1'b1;
        waddr = {w_q[ADDR_W-2:0], 1'b1};
        wdata = push_val;
      end
      OP_LEFT: begin
        w_d    = {w_q[ADDR_W-2:0], 1'b0};
        size_d = half;
      end
      OP_RIGHT: begin
        w_d    = {w_q[ADDR_W-2:0], 1'b1};
        l_d    = l_q + cell_t'(half);
        size_d = half;
      end
      OP_UP: begin
        was_left_d = ~w_q[0];
        w_d        = w_q >> 1;
        size_d     = size_q << 1;
        if (w_q[0]) begin
          l_d = l_q - cell_t'(size_q);
        end
      end
      OP_RDL: begin
        re    = 1'b1;
        raddr = {w_q[ADDR_W-2:0], 1'b0};
      end
      OP_RDR: begin
        re    = 1'b1;
        raddr = {w_q[ADDR_W-2:0], 1'b1};
      end
      OP_SUM: begin
        we    = 1'b1;
        wdata = left_q + rdata;
      end
      OP_RDROOT: begin
        re    = 1'b1;
        raddr = addr_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= addr_t'(1);
      l_q        <= '0;
      size_q     <= cnt_t'(LEAVES);
      was_left_q <= 1'b0;
      clr_q      <= '0;
    end else begin
      w_q        <= w_d;
      l_q        <= l_d;
      size_q     <= size_d;
      was_left_q <= was_left_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      lo_q    <= start_req_i;
      hi_q    <= end_req_i;
      white_q <= func_i;
    end
    if (op_i == OP_RDR) begin
      left_q <= rdata;
    end
  end

  rpct_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign status_o.clr_done  = (clr_q == addr_t'(NODES - 1));
  assign status_o.range_ok  = (start_req_i <= end_req_i);
  assign status_o.covered   = (lo_q <= l_q) && (cnt_t'(hi_q) >= p);
  assign status_o.uniform   = (rdata == '0) || (rdata == size_q);
  assign status_o.is_root   = (w_q == addr_t'(1));
  assign status_o.was_left  = was_left_q;
  assign status_o.lo_le_mid = (cnt_t'(lo_q) <= mid);
  assign status_o.hi_gt_mid = (cnt_t'(hi_q) > mid);
  assign white_count_o      = rdata;

endmodule

>>> src/rpct_ctrl.sv
// controller: tree walk sequencer
module rpct_ctrl import rpct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o,
  output logic       busy_o,
  output logic       valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    valid_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          op_o    = OP_LOAD;
          state_d = status_i.range_ok ? S_RD : S_OUTR;
        end
      end
      S_RD: begin
        op_o    = OP_VISIT;
        state_d = status_i.covered ? S_UP : S_CHK;
      end
      S_CHK: begin
        if (status_i.uniform) begin
          op_o    = OP_PUSHL;
          state_d = S_PUSHR;
        end else begin
          state_d = S_DESC;
        end
      end
      S_PUSHR: begin
        op_o    = OP_PUSHR;
        state_d = S_DESC;
      end
      S_DESC: begin
        op_o    = status_i.lo_le_mid ? OP_LEFT : OP_RIGHT;
        state_d = S_RD;
      end
      S_UP: begin
        if (status_i.is_root) begin
          state_d = S_OUTR;
        end else begin
          op_o    = OP_UP;
          state_d = S_AFTER;
        end
      end
      S_AFTER: begin
        if (status_i.was_left && status_i.hi_gt_mid) begin
          op_o    = OP_RIGHT;
          state_d = S_RD;
        end else begin
          op_o    = OP_RDL;
          state_d = S_RDR;
        end
      end
      S_RDR: begin
        op_o    = OP_RDR;
        state_d = S_SUM;
      end
      S_SUM: begin
        op_o    = OP_SUM;
        state_d = S_UP;
      end
      S_OUTR: begin
        op_o    = OP_RDROOT;
        state_d = S_OUT;
      end
      S_OUT: begin
        valid_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> src/range_paint_count_tree.sv
// top level of the range paint count tree
//
// a request paints cells start_req_i..end_req_i (inclusive) white when
// func_i is 1 or black when 0, and returns the number of white cells.
// a request is taken at a clock edge with start_i high and busy_o low.
// the result sits on white_count_o for one cycle with valid_o high;
// the receiver cannot stall it.
// a request with start after end goes straight to the root read and the
// result, as does one that paints the whole row after the root visit.
// each visited node below the root takes a read, a step up and a
// decision, and each split node adds a check, a push to its children
// when it is uniform, a descent, reads of both children and a sum.
// one request is in flight at a time; the next one is taken in the
// cycle after the strobe. the memory's single read port sets the steps.
// after reset every cell is black: a clearing pass writes all 2048
// nodes, one per cycle, and busy_o stays high until it is done.
module range_paint_count_tree import rpct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [9:0]  start_req_i,
  input  logic [9:0]  end_req_i,
  input  logic        func_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic [10:0] white_count_o
);

  dp_op_e     op;
  dp_status_t status;

  rpct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .op_o    (op),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  rpct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .start_req_i  (start_req_i),
    .end_req_i    (end_req_i),
    .func_i       (func_i),
    .status_o     (status),
    .white_count_o(white_count_o)
  );

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (white_count_o <= 11'(LEAVES))) else $error("count beyond row");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");

endmodule

>>> dv/testbench.sv
// testbench for the range paint count tree: directed and random paint requests checked against a lazy tree model
module testbench import rpct_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cell_t lo;
    cell_t hi;
    logic  white;
  } paint_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [9:0]  start_req_i = '0;
  logic [9:0]  end_req_i = '0;
  logic        func_i = 1'b0;
  logic        busy_o;
  logic        valid_o;
  logic [10:0] white_count_o;

  range_paint_count_tree u_top (.*);

  always #5 clk_i = ~clk_i;

  paint_req_t  pending_q[$];
  logic [10:0] count_q[$];
  int unsigned node_cnt[4096];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          stim_done = 1'b0;

  function automatic void paint(int unsigned lo, int unsigned hi, int unsigned w,
                                int unsigned l, int unsigned p, bit white);
    int unsigned mid;
    if (lo <= l && hi >= p) begin
      node_cnt[w] = white ? (p - l + 1) : 0;
      return;
    end
    mid = l + (p - l) / 2;
    if (node_cnt[w] == p - l + 1) begin
      node_cnt[2*w] = mid - l + 1;
      node_cnt[2*w+1] = p - mid;
    end else if (node_cnt[w] == 0) begin
      node_cnt[2*w] = 0;
      node_cnt[2*w+1] = 0;
    end
    if (lo <= mid) paint(lo, hi, 2*w, l, mid, white);
    if (hi > mid) paint(lo, hi, 2*w+1, mid + 1, p, white);
    node_cnt[w] = node_cnt[2*w] + node_cnt[2*w+1];
  endfunction

  function automatic logic [10:0] predict_count(paint_req_t r);
    if (r.lo <= r.hi) paint(r.lo, r.hi, 1, 0, LEAVES - 1, r.white);
    return node_cnt[1][10:0];
  endfunction

  function automatic void add(int lo, int hi, bit white);
    paint_req_t r;
    r.lo = cell_t'(lo);
    r.hi = cell_t'(hi);
    r.white = white;
    pending_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        count_q.push_back(predict_count('{start_req_i, end_req_i, func_i}));
      end
      if (!start_i || !busy_o) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          paint_req_t r;
          r = pending_q.pop_front();
          start_i <= 1'b1;
          start_req_i <= r.lo;
          end_req_i <= r.hi;
          func_i <= r.white;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o) begin
      if (count_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", white_count_o);
      end else begin
        logic [10:0] exp_cnt;
        exp_cnt = count_q.pop_front();
        if (white_count_o !== exp_cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("white_count mismatch: expected %0d got %0d", exp_cnt, white_count_o);
        end
      end
    end
  end

  initial begin
    int lo;
    int hi;
    int span;
    add(0, 1023, 1);
    add(0, 1023, 0);
    add(0, 0, 1);
    add(1023, 1023, 1);
    add(512, 511, 1);
    add(1023, 0, 0);
    add(5, 5, 0);
    add(0, 1023, 1);
    add(300, 700, 0);
    add(511, 512, 0);
    add(299, 701, 1);
    add(0, 1, 0);
    add(1022, 1023, 0);
    add(682, 341, 1);
    add(341, 682, 1);
    add(0, 1023, 0);
    add(1023, 1023, 0);
    for (int i = 0; i < 1430; i++) begin
      lo = $urandom_range(1023);
      case ($urandom_range(3))
        0: span = $urandom_range(3);
        1: span = $urandom_range(63);
        2: span = $urandom_range(1023);
        default: span = -$urandom_range(40);
      endcase
      hi = lo + span;
      if (hi > 1023) hi = 1023;
      if (hi < 0) hi = 0;
      add(lo, hi, $urandom_range(1));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wait (!busy_o);
    repeat (3000) @(posedge clk_i);
    quiet = 1'b1;
    repeat (5000) @(posedge clk_i);
    quiet = 1'b0;
    wait (pending_q.size() == 0 && !start_i);
    wait (count_q.size() == 0);
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || cycles >= 2000000);
    if (stim_done && mismatches == 0 && count_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
